// ===== rtl/s2i_pkg.sv =====
// Shared types, constants and helper functions for the string to int64 parser.
// Used by s2i_cfg_regs, s2i_step and string_to_int64_parser_core.
`timescale 1ns / 1ps

package s2i_pkg;

    localparam int VALUE_W  = 64;
    localparam int END_W    = 16;
    localparam int BASE_W   = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register index decoded from paddr[2]
    localparam logic REG_IDX_NUMBER_BASE = 1'b0;
    localparam logic REG_IDX_SIGNED_MODE = 1'b1;

    localparam logic [BASE_W-1:0] BASE_AUTO    = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT     = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 5'd16;
    localparam logic [BASE_W-1:0] DIGIT_NONE   = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef enum logic [2:0] {
        PH_WS1,
        PH_WS2,
        PH_LEAD,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [VALUE_W-1:0]  accumulator;
        logic                negative_flag;
        logic [BASE_W-1:0]   active_base;
        logic                prefix_possible;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:           PH_WS1,
        accumulator:     '0,
        negative_flag:   1'b0,
        active_base:     BASE_AUTO,
        prefix_possible: 1'b0
    };

    typedef struct packed {
        logic [BASE_W-1:0] number_base;
        logic              signed_mode;
    } cfg_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = c - CH_LO_A + 8'd10;
        end
        else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = c - CH_UP_A + 8'd10;
        end
        else begin
            d = {3'b000, DIGIT_NONE};
        end
        return d[BASE_W-1:0];
    endfunction

endpackage

// ===== rtl/s2i_cfg_regs.sv =====
// APB-style configuration registers: number_base and signed_mode.
// Depends on s2i_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module s2i_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [s2i_pkg::PADDR_W-1:0]   paddr,
    input  logic [s2i_pkg::PDATA_W-1:0]   pwdata,
    output logic [s2i_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output s2i_pkg::cfg_t                 cfg
);
    import s2i_pkg::*;

    logic [BASE_W-1:0] number_base_reg;
    logic              signed_mode_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_AUTO;
            signed_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_IDX_NUMBER_BASE: number_base_reg <= pwdata[BASE_W-1:0];
                REG_IDX_SIGNED_MODE: signed_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_NUMBER_BASE: prdata = {{(PDATA_W-BASE_W){1'b0}}, number_base_reg};
            REG_IDX_SIGNED_MODE: prdata = {{(PDATA_W-1){1'b0}}, signed_mode_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.number_base = number_base_reg;
    assign cfg.signed_mode = signed_mode_reg;

endmodule

// ===== rtl/s2i_step.sv =====
// One parse step: next parse state, offset and result for one character.
// Depends on s2i_pkg for the phase enum, state struct and character helpers.
`timescale 1ns / 1ps

module s2i_step #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                          start_req,
    input  logic [7:0]                    char_byte,
    input  s2i_pkg::cfg_t                 cfg,
    input  s2i_pkg::parse_state_t         state_in,
    input  logic [OFFSET_WIDTH-1:0]       offset_in,
    output s2i_pkg::parse_state_t         state_next,
    output logic [OFFSET_WIDTH-1:0]       offset_next,
    output logic                          emit,
    output logic [s2i_pkg::VALUE_W-1:0]   value
);
    import s2i_pkg::*;

    parse_state_t        cur;
    logic [OFFSET_WIDTH-1:0] cur_off;
    logic                blank;
    logic [BASE_W-1:0]   digit;
    logic [BASE_W-1:0]   dbase;
    logic                consume;
    logic                do_lead;
    logic                do_digits;
    logic [VALUE_W-1:0]  partial [BASE_W];
    logic [VALUE_W-1:0]  mac;

    assign cur     = start_req ? STATE_CLEAR : state_in;
    assign cur_off = start_req ? '0 : offset_in;
    assign blank   = is_blank(char_byte);
    assign digit   = digit_of(char_byte);
    assign value   = cur.negative_flag ? (VALUE_W'(0) - cur.accumulator) : cur.accumulator;

    // accumulator * dbase + digit as shift-and-add over the base bits
    always_comb
    begin
        for (int i = 0; i < BASE_W; i++)
        begin
            partial[i] = dbase[i] ? (cur.accumulator << i) : '0;
        end
        mac = partial[0] + partial[1] + partial[2] + partial[3] + partial[4]
            + {{(VALUE_W-BASE_W){1'b0}}, digit};
    end

    always_comb
    begin
        state_next = cur;
        consume    = 1'b0;
        do_lead    = 1'b0;
        do_digits  = 1'b0;
        dbase      = cur.active_base;
        emit       = 1'b0;

        unique case (cur.phase)
            PH_WS1:
            begin
                if (blank)
                begin
                    consume = 1'b1;
                end
                else if (cfg.signed_mode && char_byte == CH_MINUS)
                begin
                    state_next.negative_flag = 1'b1;
                    consume                  = 1'b1;
                    state_next.phase         = PH_WS2;
                end
                else if (char_byte == CH_PLUS)
                begin
                    consume          = 1'b1;
                    state_next.phase = cfg.signed_mode ? PH_WS2 : PH_LEAD;
                end
                else
                begin
                    do_lead = 1'b1;
                end
            end
            PH_WS2:
            begin
                if (blank)
                begin
                    consume = 1'b1;
                end
                else if (char_byte == CH_PLUS)
                begin
                    consume          = 1'b1;
                    state_next.phase = PH_LEAD;
                end
                else
                begin
                    do_lead = 1'b1;
                end
            end
            PH_LEAD:
            begin
                do_lead = 1'b1;
            end
            PH_ZERO:
            begin
                state_next.prefix_possible = 1'b0;
                if (char_byte == CH_LO_X || char_byte == CH_UP_X)
                begin
                    state_next.active_base = BASE_HEX;
                    consume                = 1'b1;
                    state_next.phase       = PH_DIGITS;
                end
                else
                begin
                    dbase                  = (cur.active_base == BASE_AUTO) ? BASE_OCT
                                                                            : cur.active_base;
                    state_next.active_base = dbase;
                    do_digits              = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                do_digits = 1'b1;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (do_lead)
        begin
            if ((cfg.number_base == BASE_AUTO || cfg.number_base == BASE_HEX)
                && char_byte == CH_ZERO)
            begin
                state_next.active_base     = cfg.number_base;
                state_next.prefix_possible = 1'b1;
                consume                    = 1'b1;
                state_next.phase           = PH_ZERO;
            end
            else
            begin
                dbase                  = (cfg.number_base == BASE_AUTO) ? BASE_DEC
                                                                       : cfg.number_base;
                state_next.active_base = dbase;
                do_digits              = 1'b1;
            end
        end

        if (do_digits)
        begin
            if (digit < DIGIT_NONE && digit < dbase)
            begin
                state_next.accumulator = mac;
                consume                = 1'b1;
                state_next.phase       = PH_DIGITS;
            end
            else
            begin
                emit             = 1'b1;
                state_next.phase = PH_DONE;
            end
        end
    end

    assign offset_next = (consume && cur_off != {OFFSET_WIDTH{1'b1}})
                       ? cur_off + OFFSET_WIDTH'(1) : cur_off;

endmodule

// ===== rtl/string_to_int64_parser_core.sv =====
// Streaming text to 64-bit integer parser, one character per request.
// The request that ends the parse is captured in the request register, and its result in the result register.
// Throughput: one character per cycle while out_stall does not hold a full result register.
// Reset clears configuration, parse state and the valid bits of both pipeline registers.
// Depends on s2i_pkg, s2i_cfg_regs and s2i_step.
`timescale 1ns / 1ps

module string_to_int64_parser_core #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [s2i_pkg::PADDR_W-1:0]   paddr,
    input  logic [s2i_pkg::PDATA_W-1:0]   pwdata,
    output logic [s2i_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_req,
    input  logic [7:0]                    char_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [s2i_pkg::VALUE_W-1:0]   value,
    output logic [s2i_pkg::END_W-1:0]     end_offset
);
    import s2i_pkg::*;

    cfg_t                    cfg;
    logic                    in_valid_reg;
    logic                    start_reg;
    logic [7:0]              char_reg;
    parse_state_t            state_reg;
    parse_state_t            state_next;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [OFFSET_WIDTH-1:0] offset_next;
    logic                    emit;
    logic [VALUE_W-1:0]      step_value;
    logic                    out_valid_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic [END_W-1:0]        end_offset_reg;
    logic [OFFSET_WIDTH+END_W-1:0] offset_ext;
    logic                    out_free;
    logic                    advance;

    s2i_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    s2i_step #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .start_req   (start_reg),
        .char_byte   (char_reg),
        .cfg         (cfg),
        .state_in    (state_reg),
        .offset_in   (offset_reg),
        .state_next  (state_next),
        .offset_next (offset_next),
        .emit        (emit),
        .value       (step_value)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign advance    = in_valid_reg && out_free;
    assign in_stall   = in_valid_reg && !out_free;
    assign offset_ext = {{END_W{1'b0}}, offset_reg};

    // Hold the request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            start_reg <= start_req;
            char_reg  <= char_byte;
        end
    end

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_CLEAR;
            offset_reg <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            offset_reg <= offset_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg      <= step_value;
            end_offset_reg <= start_reg ? '0 : offset_ext[END_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_offset = end_offset_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for string_to_int64_parser_core: streams characters,
// predicts parsed numbers. Directed table first, then random strings across register settings.
// Depends on rtl/s2i_pkg.sv and rtl/string_to_int64_parser_core.sv.
`timescale 1ns / 1ps

module tb;

    import s2i_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_NUMBER_BASE = {REG_IDX_NUMBER_BASE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SIGNED_MODE = {REG_IDX_SIGNED_MODE, 2'b00};
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_SLACK    = 8;
    localparam int SWEEP_COUNT    = 10;
    localparam int CHARS_PER_PASS = 45;
    localparam int ROW_COUNT      = 25;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic               sgn;
        logic               start;
        logic [7:0]         ch;
        logic               known;
        logic [VALUE_W-1:0] number;
        logic [END_W-1:0]   offset;
    } stim_row_t;

    typedef struct packed {
        logic [VALUE_W-1:0] number;
        logic [END_W-1:0]   offset;
    } parsed_t;

    localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{BASE_AUTO, 1'b0, 1'b0, "7",      1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b0, 1'b0, 8'h00,    1'b1, 64'd7, 16'd1},
        '{BASE_AUTO, 1'b1, 1'b1, CH_SPACE, 1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_MINUS, 1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_TAB,   1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_PLUS,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_ZERO,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_LO_X,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_UP_F,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, CH_LO_F,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, "g",      1'b1, 64'hFFFF_FFFF_FFFF_FF01, 16'd8},
        '{BASE_AUTO, 1'b1, 1'b1, CH_ZERO,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, "7",      1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b1, 1'b0, "8",      1'b1, 64'd7, 16'd2},
        '{BASE_AUTO, 1'b0, 1'b1, CH_ZERO,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b0, 1'b0, CH_UP_X,  1'b0, 64'd0, 16'd0},
        '{BASE_AUTO, 1'b0, 1'b0, 8'hFF,    1'b1, 64'd0, 16'd2},
        '{BASE_AUTO, 1'b0, 1'b1, CH_MINUS, 1'b1, 64'd0, 16'd0},
        '{BASE_HEX,  1'b0, 1'b1, CH_PLUS,  1'b0, 64'd0, 16'd0},
        '{BASE_HEX,  1'b0, 1'b0, CH_ZERO,  1'b0, 64'd0, 16'd0},
        '{BASE_HEX,  1'b0, 1'b0, CH_LO_X,  1'b0, 64'd0, 16'd0},
        '{BASE_HEX,  1'b0, 1'b0, CH_UP_A,  1'b0, 64'd0, 16'd0},
        '{BASE_HEX,  1'b0, 1'b0, 8'h00,    1'b1, 64'd10, 16'd4},
        '{5'd1,      1'b1, 1'b1, CH_ZERO,  1'b0, 64'd0, 16'd0},
        '{5'd1,      1'b1, 1'b0, "1",      1'b1, 64'd0, 16'd1}
    };

    localparam logic [BASE_W-1:0] SWEEP_BASE [SWEEP_COUNT] = '{
        BASE_AUTO, BASE_DEC, BASE_HEX, BASE_OCT, BASE_AUTO, 5'd2, 5'd31, 5'd1, BASE_HEX, 5'd17
    };
    localparam logic SWEEP_SIGN [SWEEP_COUNT] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 start_req = 1'b0;
    logic [7:0]           char_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [VALUE_W-1:0]   value;
    logic [END_W-1:0]     end_offset;

    // typed expectation travels with the request
    logic                 row_known = 1'b0;
    logic [VALUE_W-1:0]   row_number = '0;
    logic [END_W-1:0]     row_offset = '0;

    logic [BASE_W-1:0]    cfg_base = BASE_AUTO;
    logic                 cfg_signed = 1'b0;

    phase_t               ps_phase = PH_WS1;
    logic [VALUE_W-1:0]   ps_acc = '0;
    logic                 ps_neg = 1'b0;
    logic [BASE_W-1:0]    ps_base = BASE_AUTO;
    logic [END_W-1:0]     ps_off = '0;
    logic                 ps_prefix = 1'b0;

    parsed_t              numbers_due [$];
    int                   fault_count = 0;
    int                   live_chars = 0;
    int                   numbers_seen = 0;
    int                   idle_cycles = 0;
    int                   settings_used = 0;
    bit                   quiet = 1'b0;
    bit                   start_pending = 1'b0;

    string_to_int64_parser_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_req  (start_req),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .end_offset (end_offset)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return c - CH_ZERO;
        end
        if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            return c - CH_LO_A + 8'd10;
        end
        if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            return c - CH_UP_A + 8'd10;
        end
        return 8'hFF;
    endfunction

    function automatic void take_char();
        if (ps_off != {END_W{1'b1}})
        begin
            ps_off = ps_off + 1'b1;
        end
    endfunction

    function automatic void parse_byte(input logic st, input logic [7:0] c,
                                       output bit emits, output parsed_t res);
        bit         taken;
        logic [7:0] d;
        emits = 1'b0;
        res = '0;
        taken = 1'b0;
        if (st)
        begin
            ps_phase = PH_WS1;
            ps_acc = '0;
            ps_neg = 1'b0;
            ps_base = BASE_AUTO;
            ps_off = '0;
            ps_prefix = 1'b0;
        end
        while (!taken)
        begin
            case (ps_phase)
                PH_WS1:
                begin
                    if (blank_char(c))
                    begin
                        take_char();
                        taken = 1'b1;
                    end
                    else if (cfg_signed && c == CH_MINUS)
                    begin
                        ps_neg = 1'b1;
                        take_char();
                        ps_phase = PH_WS2;
                        taken = 1'b1;
                    end
                    else if (c == CH_PLUS)
                    begin
                        take_char();
                        ps_phase = cfg_signed ? PH_WS2 : PH_LEAD;
                        taken = 1'b1;
                    end
                    else
                    begin
                        ps_phase = PH_LEAD;
                    end
                end
                PH_WS2:
                begin
                    if (blank_char(c))
                    begin
                        take_char();
                        taken = 1'b1;
                    end
                    else if (c == CH_PLUS)
                    begin
                        take_char();
                        ps_phase = PH_LEAD;
                        taken = 1'b1;
                    end
                    else
                    begin
                        ps_phase = PH_LEAD;
                    end
                end
                PH_LEAD:
                begin
                    if ((cfg_base == BASE_AUTO || cfg_base == BASE_HEX) && c == CH_ZERO)
                    begin
                        ps_base = cfg_base;
                        ps_prefix = 1'b1;
                        take_char();
                        ps_phase = PH_ZERO;
                        taken = 1'b1;
                    end
                    else
                    begin
                        ps_base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
                        ps_phase = PH_DIGITS;
                    end
                end
                PH_ZERO:
                begin
                    ps_prefix = 1'b0;
                    if (c == CH_LO_X || c == CH_UP_X)
                    begin
                        ps_base = BASE_HEX;
                        take_char();
                        ps_phase = PH_DIGITS;
                        taken = 1'b1;
                    end
                    else
                    begin
                        if (ps_base == BASE_AUTO)
                        begin
                            ps_base = BASE_OCT;
                        end
                        ps_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    d = digit_value(c);
                    if (d < 8'd16 && d < {3'b000, ps_base})
                    begin
                        ps_acc = ps_acc * {{(VALUE_W-BASE_W){1'b0}}, ps_base}
                                 + {{(VALUE_W-8){1'b0}}, d};
                        take_char();
                    end
                    else
                    begin
                        res.number = ps_neg ? {VALUE_W{1'b0}} - ps_acc : ps_acc;
                        res.offset = ps_off;
                        emits = 1'b1;
                        ps_phase = PH_DONE;
                    end
                    taken = 1'b1;
                end
                default:
                begin
                    taken = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    always @(posedge clk)
    begin
        bit      emits;
        bit      busy;
        parsed_t res;
        parsed_t due;
        if (rst_n)
        begin
            busy = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                busy = 1'b1;
                if (paddr[2] == REG_IDX_NUMBER_BASE)
                begin
                    cfg_base = pwdata[BASE_W-1:0];
                end
                else
                begin
                    cfg_signed = pwdata[0];
                end
            end
            if (in_valid && !in_stall)
            begin
                busy = 1'b1;
                if (start_req || ps_phase != PH_DONE)
                begin
                    live_chars++;
                end
                parse_byte(start_req, char_byte, emits, res);
                if (row_known)
                begin
                    numbers_due.push_back({row_number, row_offset});
                end
                else if (emits)
                begin
                    numbers_due.push_back(res);
                end
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                numbers_seen++;
                if (numbers_due.size() == 0)
                begin
                    note_fault($sformatf("unexpected result: value %h offset %0d",
                                         value, end_offset));
                end
                else
                begin
                    due = numbers_due.pop_front();
                    if (value !== due.number || end_offset !== due.offset)
                    begin
                        note_fault($sformatf(
                            "mismatch: value exp %h got %h, offset exp %0d got %0d",
                            due.number, value, due.offset, end_offset));
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results pending", numbers_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end

    task automatic push_byte(input logic st, input logic [7:0] c, input logic known,
                             input logic [VALUE_W-1:0] num, input logic [END_W-1:0] off);
        while (!quiet && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_req <= st;
        char_byte <= c;
        row_known <= known;
        row_number <= num;
        row_offset <= off;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic feed_char(input logic [7:0] c);
        push_byte(start_pending, c, 1'b0, '0, '0);
        start_pending = 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (numbers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SLACK) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            note_fault($sformatf("register %0d read back %h, exp %h", addr, got, want));
        end
    endtask

    task automatic apply_setting(input logic [BASE_W-1:0] base, input logic sgn);
        drain();
        write_reg(ADDR_NUMBER_BASE, {{(PDATA_W-BASE_W){1'b0}}, base});
        write_reg(ADDR_SIGNED_MODE, {{(PDATA_W-1){1'b0}}, sgn});
        read_reg(ADDR_NUMBER_BASE, {{(PDATA_W-BASE_W){1'b0}}, base});
        read_reg(ADDR_SIGNED_MODE, {{(PDATA_W-1){1'b0}}, sgn});
        settings_used++;
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
        begin
            return CH_ZERO + v[7:0];
        end
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + v[7:0] - 8'd10;
    endfunction

    task automatic send_random_string(input bit fresh);
        int radix;
        int ndig;
        int i;
        int r;
        start_pending = fresh;
        repeat ($urandom_range(0, 3)) feed_char(random_blank());
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            feed_char(CH_MINUS);
        end
        else if (r == 1)
        begin
            feed_char(CH_PLUS);
        end
        if (cfg_signed && r <= 1 && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(0, 2)) feed_char(random_blank());
            feed_char(CH_PLUS);
        end
        radix = (cfg_base == BASE_AUTO) ? 10 : (cfg_base > 16 ? 16 : cfg_base);
        if (cfg_base == BASE_AUTO || cfg_base == BASE_HEX)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                feed_char(CH_ZERO);
                feed_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                radix = 16;
            end
            else if (r < 5)
            begin
                feed_char(CH_ZERO);
                radix = (cfg_base == BASE_AUTO) ? 8 : 16;
            end
        end
        ndig = ($urandom_range(0, 99) < 15) ? $urandom_range(17, 26) : $urandom_range(0, 12);
        for (i = 0; i < ndig; i++)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                feed_char(digit_char($urandom_range(0, 15)));
            end
            else
            begin
                feed_char(digit_char($urandom_range(0, radix - 1)));
            end
        end
        feed_char($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 30)
        begin
            repeat ($urandom_range(1, 3)) feed_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_noise();
        start_pending = ($urandom_range(0, 1) == 1);
        repeat ($urandom_range(1, 8))
        begin
            feed_char(8'($urandom_range(0, 255)));
            start_pending = ($urandom_range(0, 99) < 5);
        end
    endtask

    initial
    begin
        int i;
        int mark;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        read_reg(ADDR_NUMBER_BASE, '0);
        read_reg(ADDR_SIGNED_MODE, '0);

        for (i = 0; i < ROW_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].base != cfg_base || DIRECTED_ROWS[i].sgn != cfg_signed)
            begin
                apply_setting(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].sgn);
            end
            push_byte(DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].known,
                      DIRECTED_ROWS[i].number, DIRECTED_ROWS[i].offset);
        end

        for (i = 0; i < SWEEP_COUNT; i++)
        begin
            apply_setting(SWEEP_BASE[i], SWEEP_SIGN[i]);
            quiet = (i == 4);
            mark = live_chars;
            // continue the unfinished string under the new setting half the time
            send_random_string($urandom_range(0, 1) == 1);
            while (live_chars - mark < CHARS_PER_PASS)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    send_random_string(1'b1);
                end
                else
                begin
                    send_noise();
                end
            end
            start_pending = 1'b1;
            feed_char(random_blank());
            feed_char(CH_MINUS);
            quiet = 1'b0;
        end

        // close with a short signed string
        apply_setting(BASE_AUTO, 1'b1);
        start_pending = 1'b1;
        for (i = 0; i < 3; i++)
        begin
            feed_char(random_blank());
        end
        feed_char(CH_MINUS);
        feed_char("9");
        feed_char(8'h00);

        drain();
        if (numbers_due.size() != 0)
        begin
            note_fault($sformatf("%0d results never arrived", numbers_due.size()));
        end
        $display("Checked %0d parsed numbers from %0d characters over %0d register settings,",
                 numbers_seen, live_chars, settings_used);
        $display("including prefixes, signs, overflow, stray bytes and mid-string changes.");
        if (fault_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
